### hw/rtl/button_debounce_short_long_press_unit_defines.svh
// Assertion macros shared by the button debounce RTL.
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDSLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDSLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bdslp_pkg.sv
// Package with types and constants for the button debounce unit.
`default_nettype none
package bdslp_pkg;

  localparam int unsigned DEB_W  = 8;
  localparam int unsigned HOLD_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 8'd3;
  localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd100;
  localparam logic [HOLD_W-1:0] HOLD_MAX         = 16'hFFFF;
  localparam logic              ACTIVE_RESET     = 1'b0;
  localparam logic              STABLE_RESET     = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd2;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HOLD_W-1:0] long_press_ticks;
    logic              active_level;
  } bdslp_cfg_t;

  typedef struct packed {
    logic short_event;
    logic long_event;
    logic debounced_level;
  } bdslp_res_t;

endpackage
`default_nettype wire

### hw/rtl/bdslp_cfg.sv
// Configuration register file for the button debounce unit.
`default_nettype none
module bdslp_cfg import bdslp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output bdslp_cfg_t                 cfg_o
);

  bdslp_cfg_t cfg_r;
  bdslp_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     cfg_nxt.debounce_ticks   = cfg_data[DEB_W-1:0];
        REG_LONG_PRESS:   cfg_nxt.long_press_ticks = cfg_data[HOLD_W-1:0];
        REG_ACTIVE_LEVEL: cfg_nxt.active_level     = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RESET;
      cfg_r.long_press_ticks <= LONG_PRESS_RESET;
      cfg_r.active_level     <= ACTIVE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bdslp_core.sv
// Debounce and press-length state machine, one sample per accepted request.
`default_nettype none
module bdslp_core import bdslp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic       pin_level,
  input  bdslp_cfg_t      cfg,
  output bdslp_res_t      res
);
  `include "button_debounce_short_long_press_unit_defines.svh"

  logic              stable_r, stable_nxt;
  logic [DEB_W-1:0]  deb_cnt_r, deb_cnt_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              long_done_r, long_done_nxt;
  logic              differs;
  logic              short_ev;
  logic              long_ev;

  assign differs = pin_level != stable_r;

  always_comb begin
    stable_nxt    = stable_r;
    deb_cnt_nxt   = deb_cnt_r;
    hold_nxt      = hold_r;
    long_done_nxt = long_done_r;
    short_ev      = 1'b0;
    long_ev       = 1'b0;

    if (differs && (deb_cnt_r < cfg.debounce_ticks)) begin
      deb_cnt_nxt = deb_cnt_r + 1'b1;
    end else if (differs) begin
      stable_nxt  = pin_level;
      deb_cnt_nxt = '0;
      if (pin_level == cfg.active_level) begin
        hold_nxt      = '0;
        long_done_nxt = 1'b0;
      end else if (!long_done_r) begin
        short_ev = 1'b1;
      end
    end else begin
      deb_cnt_nxt = '0;
    end

    // A steady pressed tick advances the saturating hold counter; the stable level is unchanged here.
    if (!differs && (stable_r == cfg.active_level)) begin
      if (hold_r != HOLD_MAX) begin
        hold_nxt = hold_r + 1'b1;
      end
      if ((hold_nxt >= cfg.long_press_ticks) && !long_done_r) begin
        long_ev       = 1'b1;
        long_done_nxt = 1'b1;
      end
    end
  end

  assign res.short_event     = short_ev;
  assign res.long_event      = long_ev;
  assign res.debounced_level = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= STABLE_RESET;
      deb_cnt_r   <= '0;
      hold_r      <= '0;
      long_done_r <= 1'b0;
    end else if (push) begin
      stable_r    <= stable_nxt;
      deb_cnt_r   <= deb_cnt_nxt;
      hold_r      <= hold_nxt;
      long_done_r <= long_done_nxt;
    end
  end

  `BDSLP_ASSERT_NOW(a_no_dual_event, push, !(short_ev && long_ev),
    "short and long events in the same tick")
  `BDSLP_ASSERT_NEXT(a_long_marks_done, push && long_ev, long_done_r,
    "long event did not mark the press as long")
  `BDSLP_ASSERT_NEXT(a_hold_counts,
    push && !differs && (stable_r == cfg.active_level) && (hold_r != HOLD_MAX),
    hold_r == $past(hold_r) + 1'b1,
    "hold counter did not advance on a steady pressed tick")

endmodule
`default_nettype wire

### hw/rtl/bdslp_obuf.sv
// Two-entry result buffer: output register plus skid entry.
`default_nettype none
module bdslp_obuf import bdslp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  bdslp_res_t push_data,
  output logic       can_push,
  output logic       out_valid,
  input  wire logic  out_ready,
  output bdslp_res_t out_data
);
  `include "button_debounce_short_long_press_unit_defines.svh"

  bdslp_res_t  head_r, head_nxt;
  bdslp_res_t  skid_r, skid_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        pop;

  assign out_valid = count_r != 2'd0;
  assign can_push  = count_r != 2'd2;
  assign out_data  = head_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    head_nxt  = head_r;
    skid_nxt  = skid_r;
    count_nxt = count_r;
    unique case ({push, pop})
      2'b11: begin
        if (count_r == 2'd2) begin
          head_nxt = skid_r;
          skid_nxt = push_data;
        end else begin
          head_nxt = push_data;
        end
      end
      2'b10: begin
        if (count_r == 2'd0) begin
          head_nxt = push_data;
        end else begin
          skid_nxt = push_data;
        end
        count_nxt = count_r + 1'b1;
      end
      2'b01: begin
        head_nxt  = skid_r;
        count_nxt = count_r - 1'b1;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  `BDSLP_ASSERT_NOW(a_count_range, 1'b1, count_r != 2'd3,
    "result buffer count out of range")
  `BDSLP_ASSERT_NEXT(a_empty_push, push && (count_r == 2'd0),
    out_valid && (head_r == $past(push_data)),
    "request into empty buffer not presented next cycle")
  `BDSLP_ASSERT_NEXT(a_skid_shift, pop && !push && (count_r == 2'd2),
    (count_r == 2'd1) && (head_r == $past(skid_r)),
    "skid entry not moved to the head after a pop")

endmodule
`default_nettype wire

### hw/rtl/button_debounce_short_long_press_unit.sv
// Top level of the button debounce unit with short and long press events.
//
//  Channel | Signals                                          | Direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, in_pin_level                 | sink
//  out     | out_valid, out_ready, out_short_event,           | source
//          | out_long_event, out_debounced_level              |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | sink
//
// One request is taken per cycle while the result buffer has room; its result is registered in the buffer.
// The state update is a single pass of counter logic between the state registers.
// A two-entry result buffer lets two requests land while the output is stalled.
// in_ready depends only on the buffer fill, not on out_ready.
// Synchronous reset restores the register defaults and the released stable level.
`default_nettype none
module button_debounce_short_long_press_unit import bdslp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_pin_level,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_short_event,
  output logic                       out_long_event,
  output logic                       out_debounced_level,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  bdslp_cfg_t cfg;
  bdslp_res_t core_res;
  bdslp_res_t out_res;
  logic       push;

  assign push = in_valid && in_ready;

  bdslp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  bdslp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pin_level (in_pin_level),
    .cfg       (cfg),
    .res       (core_res)
  );

  bdslp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_short_event     = out_res.short_event;
  assign out_long_event      = out_res.long_event;
  assign out_debounced_level = out_res.debounced_level;

endmodule
`default_nettype wire
